@@ sv/dtd_pkg.sv @@
// Shared types, constants and calendar tables for the date-time difference block.
package dtd_pkg;

  localparam int unsigned DAYS_W = 22;
  localparam logic [13:0] MAX_YEAR = 14'd9999;

  // Month codes
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [4:0]  day_a;
    logic [3:0]  month_a;
    logic [13:0] year_a;
    logic [4:0]  hour_a;
    logic [5:0]  minute_a;
    logic [5:0]  second_a;
    logic [4:0]  day_b;
    logic [3:0]  month_b;
    logic [13:0] year_b;
    logic [4:0]  hour_b;
    logic [5:0]  minute_b;
    logic [5:0]  second_b;
  } in_t;

  typedef struct packed {
    logic              invalid;
    logic [DAYS_W-1:0] diff_days;
    logic [4:0]        diff_hours;
    logic [5:0]        diff_minutes;
    logic [5:0]        diff_seconds;
  } out_t;

  // One calendar date-time as it arrives
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_time_t;

  // Day number since 0001-01-01 plus time of day; order makes a packed compare valid
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } stamp_t;

  // Days before the first of a month in a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of a month in a common year
  function automatic logic [4:0] month_length(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        len = 5'd31;
      default:                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ sv/dtd_convert.sv @@
// Validation and day-number conversion of one date-time.
module dtd_convert (
  input  dtd_pkg::date_time_t dt,
  output dtd_pkg::stamp_t     stamp,
  output logic                ok
);
  import dtd_pkg::*;

  logic [13:0] py;
  logic [11:0] q4;
  logic [23:0] prod;
  logic [7:0]  q100;
  logic [13:0] r100_full;
  logic [6:0]  r100;
  logic        leap;
  logic [4:0]  len;
  logic [22:0] days_sum;

  // Split the elapsed years into quarters, centuries and the leftover
  always_comb begin
    py        = dt.year - 14'd1;
    q4        = py[13:2];
    // q4 / 25 by reciprocal; exact for q4 below 4096
    prod      = {12'd0, q4} * 24'd2622;
    q100      = prod[23:16];
    r100_full = py - ({6'd0, q100} * 14'd100);
    r100      = r100_full[6:0];
  end

  // Leap rule on year = py + 1
  always_comb begin
    if (r100 == 7'd99) begin
      leap = (q100[1:0] == 2'd3);
    end else begin
      leap = (py[1:0] == 2'd3);
    end
  end

  // Check every field against its calendar range
  always_comb begin
    len = month_length(dt.month);
    if (dt.month == MONTH_FEB && leap) begin
      len = 5'd29;
    end
    ok = (dt.year != 14'd0) && (dt.year <= MAX_YEAR) &&
         (dt.month inside {[MONTH_JAN:MONTH_DEC]}) &&
         (dt.day != 5'd0) && (dt.day <= len) &&
         (dt.hour <= 5'd23) && (dt.minute <= 6'd59) && (dt.second <= 6'd59);
  end

  // Sum the day number since 0001-01-01
  always_comb begin
    days_sum = ({9'd0, py} * 23'd365)
             + {11'd0, q4}
             - {15'd0, q100}
             + {17'd0, q100[7:2]}
             + {14'd0, days_before_month(dt.month)}
             + {22'd0, (dt.month > MONTH_FEB) && leap}
             + {18'd0, dt.day}
             - 23'd1;
    stamp.days   = days_sum[DAYS_W-1:0];
    stamp.hour   = dt.hour;
    stamp.minute = dt.minute;
    stamp.second = dt.second;
  end

endmodule

@@ sv/dtd_diff.sv @@
// Absolute difference of two day-number stamps with borrow through seconds, minutes, hours.
module dtd_diff (
  input  dtd_pkg::stamp_t stamp_a,
  input  dtd_pkg::stamp_t stamp_b,
  input  logic            bad,
  output dtd_pkg::out_t   res
);
  import dtd_pkg::*;

  stamp_t     big;
  stamp_t     sml;
  logic [6:0] sec_raw;
  logic [6:0] min_raw;
  logic [5:0] hr_raw;
  logic       sec_bw;
  logic       min_bw;
  logic       hr_bw;
  logic [5:0] sec_d;
  logic [5:0] min_d;
  logic [4:0] hr_d;
  logic [DAYS_W-1:0] day_d;

  // Order the two stamps so the subtraction is non-negative
  always_comb begin
    if (stamp_a >= stamp_b) begin
      big = stamp_a;
      sml = stamp_b;
    end else begin
      big = stamp_b;
      sml = stamp_a;
    end
  end

  // Subtract field by field, borrowing upward
  always_comb begin
    sec_raw = {1'b0, big.second} - {1'b0, sml.second};
    sec_bw  = sec_raw[6];
    sec_d   = sec_bw ? (sec_raw[5:0] + 6'd60) : sec_raw[5:0];

    min_raw = {1'b0, big.minute} - {1'b0, sml.minute} - {6'd0, sec_bw};
    min_bw  = min_raw[6];
    min_d   = min_bw ? (min_raw[5:0] + 6'd60) : min_raw[5:0];

    hr_raw  = {1'b0, big.hour} - {1'b0, sml.hour} - {5'd0, min_bw};
    hr_bw   = hr_raw[5];
    hr_d    = hr_bw ? (hr_raw[4:0] + 5'd24) : hr_raw[4:0];

    day_d   = big.days - sml.days - {{(DAYS_W-1){1'b0}}, hr_bw};
  end

  // Zero the result when either input fails validation
  always_comb begin
    res.invalid = bad;
    if (bad) begin
      res.diff_days    = '0;
      res.diff_hours   = '0;
      res.diff_minutes = '0;
      res.diff_seconds = '0;
    end else begin
      res.diff_days    = day_d;
      res.diff_hours   = hr_d;
      res.diff_minutes = min_d;
      res.diff_seconds = sec_d;
    end
  end

endmodule

@@ sv/date_time_difference.sv @@
// Top level: three-register pipeline computing the difference of two date-times.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_data  (dtd_pkg::in_t)
//   out_     output     out_valid/out_ready  out_data (dtd_pkg::out_t)
//
// One item per cycle while results are taken; an accepted item passes through the
// input register, conversion register and result register in turn, and out_valid
// rises when it reaches the result register.
// The conversion stage holds the longest path: one reciprocal multiply per date.
// Synchronous active-low reset empties all stages; payload registers are not reset.
// While a result waits with out_ready low, every stage holds and in_ready drops.
module date_time_difference (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dtd_pkg::out_t  out_data
);
  import dtd_pkg::*;

  logic       adv;
  logic       in_valid_r;
  in_t        in_r;
  logic       s1_valid_r;
  logic       s1_bad_r;
  stamp_t     s1_a_r;
  stamp_t     s1_b_r;
  logic       out_valid_r;
  out_t       out_data_r;

  date_time_t dt_a;
  date_time_t dt_b;
  stamp_t     stamp_a;
  stamp_t     stamp_b;
  logic       ok_a;
  logic       ok_b;
  out_t       res;

  // Advance all stages whenever the result register can take a new value
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Regroup the registered input into two date-times
  always_comb begin
    dt_a = '{day: in_r.day_a, month: in_r.month_a, year: in_r.year_a,
             hour: in_r.hour_a, minute: in_r.minute_a, second: in_r.second_a};
    dt_b = '{day: in_r.day_b, month: in_r.month_b, year: in_r.year_b,
             hour: in_r.hour_b, minute: in_r.minute_b, second: in_r.second_b};
  end

  dtd_convert u_conv_a (
    .dt    (dt_a),
    .stamp (stamp_a),
    .ok    (ok_a)
  );

  dtd_convert u_conv_b (
    .dt    (dt_b),
    .stamp (stamp_b),
    .ok    (ok_b)
  );

  dtd_diff u_diff (
    .stamp_a (s1_a_r),
    .stamp_b (s1_b_r),
    .bad     (s1_bad_r),
    .res     (res)
  );

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r  <= in_valid;
      s1_valid_r  <= in_valid_r;
      out_valid_r <= s1_valid_r;
    end
  end

  // Payload of the three stages
  always_ff @(posedge clk) begin
    if (adv) begin
      in_r       <= in_data;
      s1_a_r     <= stamp_a;
      s1_b_r     <= stamp_b;
      s1_bad_r   <= !(ok_a && ok_b);
      out_data_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted transfer sits in the input register next cycle
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> in_valid_r)
    else $error("accepted transfer did not reach input register");

  // A converted item reaches the result register next cycle when advancing
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv |=> out_valid_r)
    else $error("converted item did not reach result register");

  // Invalid results carry all-zero difference fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.invalid |->
      (out_data_r.diff_days == '0) && (out_data_r.diff_hours == 5'd0) &&
      (out_data_r.diff_minutes == 6'd0) && (out_data_r.diff_seconds == 6'd0))
    else $error("invalid result has nonzero fields");

  // Valid results keep remainders within a day
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.invalid |->
      (out_data_r.diff_hours <= 5'd23) && (out_data_r.diff_minutes <= 6'd59) &&
      (out_data_r.diff_seconds <= 6'd59))
    else $error("remainder field out of range");
`endif

endmodule
